/* src/ucf_pkg.sv */
`timescale 1ns / 1ps
// ucf_pkg: shared types and codes for the serial byte buffer with realtime
// command filtering. No dependencies.
package ucf_pkg;

  // Item operation codes
  localparam logic [2:0] OP_RX    = 3'd0;  // line byte received
  localparam logic [2:0] OP_READ  = 3'd1;  // host read
  localparam logic [2:0] OP_WRITE = 3'd2;  // host write
  localparam logic [2:0] OP_TXRDY = 3'd3;  // transmitter ready
  localparam logic [2:0] OP_FLUSH = 3'd4;  // flush receive ring

  // Realtime event codes
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_STATUS = 3'd1;
  localparam logic [2:0] EV_START  = 3'd2;
  localparam logic [2:0] EV_HOLD   = 3'd3;
  localparam logic [2:0] EV_DOOR   = 3'd4;
  localparam logic [2:0] EV_ABORT  = 3'd5;

  typedef struct packed {
    logic [7:0] status_char;
    logic [7:0] start_char;
    logic [7:0] hold_char;
    logic [7:0] door_char;
    logic [7:0] abort_char;
    logic       flow_enable;
    logic [6:0] high_mark;
    logic [6:0] low_mark;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic [2:0] ev;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [2:0] rt_event;
    logic       write_accepted;
    logic       rx_dropped;
    logic [6:0] rx_fill;
    logic       tx_pending;
  } res_t;

endpackage

/* src/ucf_fifo.sv */
`timescale 1ns / 1ps
// ucf_fifo: two-entry queue of any packed type.
// No dependencies.
module ucf_fifo #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic rd_i,
  output T     rdata_o,
  output logic empty_o
);

  T           mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wp_q <= ~wp_q;
      if (do_rd) rp_q <= ~rp_q;
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wdata_i;
  end

endmodule

/* src/ucf_front.sv */
`timescale 1ns / 1ps
// ucf_front: accepts items, tags realtime characters with their event code,
// queues classified items for the back end. Uses ucf_pkg and ucf_fifo.
module ucf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [2:0]    op_i,
  input  logic [7:0]    data_i,
  input  ucf_pkg::cfg_t cfg_i,
  output ucf_pkg::cmd_t cmd_o,
  output logic          cmd_empty_o,
  input  logic          cmd_pop_i
);
  import ucf_pkg::*;

  cmd_t cmd_in;

  // First match wins, in priority order status, start, hold, door, abort
  always_comb begin
    cmd_in.op   = op_i;
    cmd_in.data = data_i;
    cmd_in.ev   = EV_NONE;
    if (op_i == OP_RX) begin
      if (data_i == cfg_i.status_char)     cmd_in.ev = EV_STATUS;
      else if (data_i == cfg_i.start_char) cmd_in.ev = EV_START;
      else if (data_i == cfg_i.hold_char)  cmd_in.ev = EV_HOLD;
      else if (data_i == cfg_i.door_char)  cmd_in.ev = EV_DOOR;
      else if (data_i == cfg_i.abort_char) cmd_in.ev = EV_ABORT;
    end
  end

  ucf_fifo #(.T(cmd_t)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .rd_i    (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

/* src/ucf_back.sv */
`timescale 1ns / 1ps
// ucf_back: executes classified items against the receive and transmit rings,
// runs XON/XOFF flow control, queues results. Uses ucf_pkg and ucf_fifo.
module ucf_back #(
  parameter int RX_DEPTH = 128,
  parameter int TX_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ucf_pkg::cfg_t cfg_i,
  input  ucf_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  output ucf_pkg::res_t res_o,
  output logic          empty,
  input  logic          pop
);
  import ucf_pkg::*;

  localparam int RPW = $clog2(RX_DEPTH);
  localparam int TPW = $clog2(TX_DEPTH);
  localparam int MW  = (RPW + 1 > 8) ? RPW + 1 : 8;

  localparam logic [7:0] XON_BYTE  = 8'h11;
  localparam logic [7:0] XOFF_BYTE = 8'h13;

  // Flow control states
  localparam logic [1:0] FL_XON_SENT  = 2'd0;
  localparam logic [1:0] FL_SEND_XOFF = 2'd1;
  localparam logic [1:0] FL_XOFF_SENT = 2'd2;
  localparam logic [1:0] FL_SEND_XON  = 2'd3;

  // Transmit byte source
  localparam logic [1:0] TXS_NONE = 2'd0;
  localparam logic [1:0] TXS_XOFF = 2'd1;
  localparam logic [1:0] TXS_XON  = 2'd2;
  localparam logic [1:0] TXS_MEM  = 2'd3;

  typedef struct packed {
    logic       rv;
    logic [1:0] tx_sel;
    logic [2:0] ev;
    logic       wa;
    logic       dr;
  } pend_t;

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_rd_q, tx_rd_q;

  logic [RPW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [TPW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [1:0]     flow_q, flow_d;
  logic           act_q, act_d;
  logic           busy_q;
  pend_t          pend_q, pend_d;

  logic           start, out_full, rx_we, tx_we;
  logic [RPW-1:0] rx_head_nx, rx_tail_nx;
  logic [TPW-1:0] tx_head_nx, tx_tail_nx;
  logic [RPW:0]   rx_cnt;
  logic [MW-1:0]  rx_cnt_w;
  logic           rx_full, rx_empty, tx_full;
  res_t           res_in;

  assign rx_head_nx = (rx_head_q == RPW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
  assign rx_tail_nx = (rx_tail_q == RPW'(RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;
  assign tx_head_nx = (tx_head_q == TPW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
  assign tx_tail_nx = (tx_tail_q == TPW'(TX_DEPTH - 1)) ? '0 : tx_tail_q + 1'b1;

  always_comb begin
    rx_cnt = {1'b0, rx_head_q} - {1'b0, rx_tail_q};
    if (rx_head_q < rx_tail_q) rx_cnt = rx_cnt + (RPW + 1)'(RX_DEPTH);
  end
  assign rx_cnt_w = MW'(rx_cnt);

  assign rx_full  = (rx_head_nx == rx_tail_q);
  assign rx_empty = (rx_head_q == rx_tail_q);
  assign tx_full  = (tx_head_nx == tx_tail_q);

  // One item at a time: execute cycle, then result cycle
  assign start     = !cmd_empty_i && !busy_q && !out_full;
  assign cmd_pop_o = start;

  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    flow_d    = flow_q;
    act_d     = act_q;
    pend_d    = pend_q;
    rx_we     = 1'b0;
    tx_we     = 1'b0;
    if (start) begin
      pend_d = '0;
      unique case (cmd_i.op)
        OP_RX: begin
          pend_d.ev = cmd_i.ev;
          if (cmd_i.ev == EV_NONE) begin
            if (!rx_full) begin
              rx_we     = 1'b1;
              rx_head_d = rx_head_nx;
              if (cfg_i.flow_enable && (rx_cnt_w + 1'b1 >= MW'(cfg_i.high_mark)) &&
                  flow_q == FL_XON_SENT) begin
                flow_d = FL_SEND_XOFF;
                act_d  = 1'b1;
              end
            end else begin
              pend_d.dr = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (!rx_empty) begin
            pend_d.rv = 1'b1;
            rx_tail_d = rx_tail_nx;
            if (cfg_i.flow_enable && (rx_cnt_w - 1'b1 < MW'(cfg_i.low_mark)) &&
                flow_q == FL_XOFF_SENT) begin
              flow_d = FL_SEND_XON;
              act_d  = 1'b1;
            end
          end
        end
        OP_WRITE: begin
          if (!tx_full) begin
            tx_we     = 1'b1;
            tx_head_d = tx_head_nx;
            act_d     = 1'b1;
            pend_d.wa = 1'b1;
          end
        end
        OP_TXRDY: begin
          if (act_q) begin
            if (cfg_i.flow_enable && flow_q == FL_SEND_XOFF) begin
              pend_d.tx_sel = TXS_XOFF;
              flow_d        = FL_XOFF_SENT;
            end else if (cfg_i.flow_enable && flow_q == FL_SEND_XON) begin
              pend_d.tx_sel = TXS_XON;
              flow_d        = FL_XON_SENT;
            end else if (tx_tail_q != tx_head_q) begin
              pend_d.tx_sel = TXS_MEM;
              tx_tail_d     = tx_tail_nx;
            end
            if (tx_tail_d == tx_head_q) act_d = 1'b0;
          end
        end
        OP_FLUSH: begin
          rx_tail_d = rx_head_q;
          flow_d    = FL_XON_SENT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      flow_q    <= FL_XON_SENT;
      act_q     <= 1'b0;
      busy_q    <= 1'b0;
    end else begin
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      flow_q    <= flow_d;
      act_q     <= act_d;
      busy_q    <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // Ring stores: one write and one registered read at the tail each cycle
  always_ff @(posedge clk_i) begin
    if (rx_we) rx_mem[rx_head_q] <= cmd_i.data;
    rx_rd_q <= rx_mem[rx_tail_q];
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) tx_mem[tx_head_q] <= cmd_i.data;
    tx_rd_q <= tx_mem[tx_tail_q];
  end

  // Result cycle: pointers already hold the post-step values
  always_comb begin
    res_in.read_data      = pend_q.rv ? rx_rd_q : 8'h00;
    res_in.read_valid     = pend_q.rv;
    case (pend_q.tx_sel)
      TXS_XOFF: res_in.tx_byte = XOFF_BYTE;
      TXS_XON:  res_in.tx_byte = XON_BYTE;
      TXS_MEM:  res_in.tx_byte = tx_rd_q;
      default:  res_in.tx_byte = 8'h00;
    endcase
    res_in.tx_valid       = (pend_q.tx_sel != TXS_NONE);
    res_in.rt_event       = pend_q.ev;
    res_in.write_accepted = pend_q.wa;
    res_in.rx_dropped     = pend_q.dr;
    res_in.rx_fill        = (rx_cnt_w > MW'(7'd127)) ? 7'd127 : rx_cnt_w[6:0];
    res_in.tx_pending     = act_q;
  end

  ucf_fifo #(.T(res_t)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (busy_q),
    .wdata_i (res_in),
    .full_o  (out_full),
    .rd_i    (pop),
    .rdata_o (res_o),
    .empty_o (empty)
  );

endmodule

/* src/uart_fifo_realtime_cmd_filter_core.sv */
`timescale 1ns / 1ps
// uart_fifo_realtime_cmd_filter_core: top level of the serial byte buffer.
// Holds the configuration registers; uses ucf_pkg, ucf_front and ucf_back.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+--------------------------------
//   item in  | input     | push / full       | op_i, data_i
//   result   | output    | empty / pop       | read_data_o .. tx_pending_o
//   config   | input     | cfg_we_i          | cfg_idx_i, cfg_data_i
//
// The back end handles each item in an execute step, which updates the ring
// pointers and flow state and starts the store read at the tail, and a
// result step, which registers the result. It takes no new item until the
// last result is queued. Two-entry queues between front and back and at the
// output let either side stall without blocking the other; the back end
// waits while the result queue is full. Reset clears pointers, flow state
// and config; ring stores are not cleared, since only written entries are
// ever read.
module uart_fifo_realtime_cmd_filter_core #(
  parameter int RX_DEPTH = 128,
  parameter int TX_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // item input
  input  logic       push,
  output logic       full,
  input  logic [2:0] op_i,
  input  logic [7:0] data_i,
  // results
  output logic       empty,
  input  logic       pop,
  output logic [7:0] read_data_o,
  output logic       read_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       tx_valid_o,
  output logic [2:0] rt_event_o,
  output logic       write_accepted_o,
  output logic       rx_dropped_o,
  output logic [6:0] rx_fill_o,
  output logic       tx_pending_o,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);
  import ucf_pkg::*;

  // Register indexes
  localparam logic [2:0] REG_STATUS = 3'd0;
  localparam logic [2:0] REG_START  = 3'd1;
  localparam logic [2:0] REG_HOLD   = 3'd2;
  localparam logic [2:0] REG_DOOR   = 3'd3;
  localparam logic [2:0] REG_ABORT  = 3'd4;
  localparam logic [2:0] REG_FLOW   = 3'd5;
  localparam logic [2:0] REG_HIGH   = 3'd6;
  localparam logic [2:0] REG_LOW    = 3'd7;

  cfg_t cfg_q;
  cmd_t cmd;
  res_t res;
  logic cmd_empty, cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.status_char <= 8'd63;
      cfg_q.start_char  <= 8'd126;
      cfg_q.hold_char   <= 8'd33;
      cfg_q.door_char   <= 8'd64;
      cfg_q.abort_char  <= 8'd24;
      cfg_q.flow_enable <= 1'b0;
      cfg_q.high_mark   <= 7'd96;
      cfg_q.low_mark    <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STATUS: cfg_q.status_char <= cfg_data_i;
        REG_START:  cfg_q.start_char  <= cfg_data_i;
        REG_HOLD:   cfg_q.hold_char   <= cfg_data_i;
        REG_DOOR:   cfg_q.door_char   <= cfg_data_i;
        REG_ABORT:  cfg_q.abort_char  <= cfg_data_i;
        REG_FLOW:   cfg_q.flow_enable <= cfg_data_i[0];
        REG_HIGH:   cfg_q.high_mark   <= cfg_data_i[6:0];
        REG_LOW:    cfg_q.low_mark    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Front: realtime character match and item queue
  ucf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .data_i      (data_i),
    .cfg_i       (cfg_q),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: rings, flow control, result queue
  ucf_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .empty       (empty),
    .pop         (pop)
  );

  assign read_data_o      = res.read_data;
  assign read_valid_o     = res.read_valid;
  assign tx_byte_o        = res.tx_byte;
  assign tx_valid_o       = res.tx_valid;
  assign rt_event_o       = res.rt_event;
  assign write_accepted_o = res.write_accepted;
  assign rx_dropped_o     = res.rx_dropped;
  assign rx_fill_o        = res.rx_fill;
  assign tx_pending_o     = res.tx_pending;

endmodule

/* verif/uart_fifo_realtime_cmd_filter_core_tb.sv */
`timescale 1ns / 1ps
// uart_fifo_realtime_cmd_filter_core_tb: self-checking bench for the serial byte buffer with
// realtime command filtering and XON/XOFF. Needs ucf_pkg and the core RTL only.
module uart_fifo_realtime_cmd_filter_core_tb;
  import ucf_pkg::*;

  // Register map of the config port
  localparam logic [2:0] REG_STATUS_CHAR = 3'd0;
  localparam logic [2:0] REG_START_CHAR  = 3'd1;
  localparam logic [2:0] REG_HOLD_CHAR   = 3'd2;
  localparam logic [2:0] REG_DOOR_CHAR   = 3'd3;
  localparam logic [2:0] REG_ABORT_CHAR  = 3'd4;
  localparam logic [2:0] REG_FLOW_ENABLE = 3'd5;
  localparam logic [2:0] REG_HIGH_MARK   = 3'd6;
  localparam logic [2:0] REG_LOW_MARK    = 3'd7;

  localparam logic [7:0] CTRL_XON  = 8'h11;
  localparam logic [7:0] CTRL_XOFF = 8'h13;

  localparam int IDLE_PCT      = 23;
  localparam int HOLD_CYCLES   = 200;   // receiver hold-off, long enough to back up the input
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 5000;

  typedef enum logic [1:0] {
    FLOW_XON_SENT,
    FLOW_SEND_XOFF,
    FLOW_XOFF_SENT,
    FLOW_SEND_XON
  } flow_e;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [2:0] op_i;
  logic [7:0] data_i;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] read_data_o;
  logic       read_valid_o;
  logic [7:0] tx_byte_o;
  logic       tx_valid_o;
  logic [2:0] rt_event_o;
  logic       write_accepted_o;
  logic       rx_dropped_o;
  logic [6:0] rx_fill_o;
  logic       tx_pending_o;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  uart_fifo_realtime_cmd_filter_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .op_i             (op_i),
    .data_i           (data_i),
    .empty            (empty),
    .pop              (pop),
    .read_data_o      (read_data_o),
    .read_valid_o     (read_valid_o),
    .tx_byte_o        (tx_byte_o),
    .tx_valid_o       (tx_valid_o),
    .rt_event_o       (rt_event_o),
    .write_accepted_o (write_accepted_o),
    .rx_dropped_o     (rx_dropped_o),
    .rx_fill_o        (rx_fill_o),
    .tx_pending_o     (tx_pending_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the buffer: rings, pointers, flow state and config
  // ---------------------------------------------------------------------------
  cfg_t       cfg;
  logic [7:0] rx_mem [128];
  logic [6:0] rx_hd, rx_tl;      // 7-bit pointers wrap at the 128-slot depth
  logic [7:0] tx_mem [64];
  logic [5:0] tx_hd, tx_tl;      // 6-bit pointers wrap at the 64-slot depth
  flow_e      flow;
  logic       tx_busy;

  res_t replies_due[$];          // one reply per accepted item, oldest first

  int   items_sent  = 0;
  int   replies_ok  = 0;
  int   err_cnt     = 0;
  logic calm        = 1'b0;      // no idling on either side while set
  logic holding     = 1'b0;      // receiver held off
  event hold_ev;
  res_t want;

  function automatic logic [6:0] rx_level();
    return 7'(rx_hd - rx_tl);
  endfunction

  // Any byte that the filter will store rather than turn into an event
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do
      b = 8'($urandom_range(255));
    while (b == cfg.status_char || b == cfg.start_char || b == cfg.hold_char ||
           b == cfg.door_char || b == cfg.abort_char);
    return b;
  endfunction

  // Apply one item to the shadow buffer and queue the reply it must produce
  task automatic buffer_step(input logic [2:0] op, input logic [7:0] data);
    res_t       r;
    logic [6:0] rx_nx;
    logic [5:0] tx_nx;
    r = '0;
    case (op)
      OP_RX: begin
        // first match wins when chars are duplicated
        if (data == cfg.status_char) r.rt_event = EV_STATUS;
        else if (data == cfg.start_char) r.rt_event = EV_START;
        else if (data == cfg.hold_char) r.rt_event = EV_HOLD;
        else if (data == cfg.door_char) r.rt_event = EV_DOOR;
        else if (data == cfg.abort_char) r.rt_event = EV_ABORT;
        else begin
          rx_nx = rx_hd + 7'd1;
          if (rx_nx == rx_tl) begin
            r.rx_dropped = 1'b1;       // ring holds one less than its slots
          end else begin
            rx_mem[rx_hd] = data;
            rx_hd = rx_nx;
            if (cfg.flow_enable && rx_level() >= cfg.high_mark && flow == FLOW_XON_SENT) begin
              flow = FLOW_SEND_XOFF;
              tx_busy = 1'b1;
            end
          end
        end
      end
      OP_READ: if (rx_hd != rx_tl) begin
        r.read_data = rx_mem[rx_tl];
        r.read_valid = 1'b1;
        rx_tl = rx_tl + 7'd1;
        if (cfg.flow_enable && rx_level() < cfg.low_mark && flow == FLOW_XOFF_SENT) begin
          flow = FLOW_SEND_XON;
          tx_busy = 1'b1;
        end
      end
      OP_WRITE: begin
        tx_nx = tx_hd + 6'd1;
        if (tx_nx != tx_tl) begin
          tx_mem[tx_hd] = data;
          tx_hd = tx_nx;
          tx_busy = 1'b1;
          r.write_accepted = 1'b1;
        end
      end
      OP_TXRDY: if (tx_busy) begin
        // pending XOFF/XON jumps ahead of queued data
        if (cfg.flow_enable && flow == FLOW_SEND_XOFF) begin
          r.tx_byte = CTRL_XOFF;
          r.tx_valid = 1'b1;
          flow = FLOW_XOFF_SENT;
        end else if (cfg.flow_enable && flow == FLOW_SEND_XON) begin
          r.tx_byte = CTRL_XON;
          r.tx_valid = 1'b1;
          flow = FLOW_XON_SENT;
        end else if (tx_tl != tx_hd) begin
          r.tx_byte = tx_mem[tx_tl];
          r.tx_valid = 1'b1;
          tx_tl = tx_tl + 6'd1;
        end
        if (tx_tl == tx_hd) tx_busy = 1'b0;
      end
      OP_FLUSH: begin
        rx_tl = rx_hd;
        flow = FLOW_XON_SENT;
      end
      default: ;                       // spare codes only report fill and pending
    endcase
    r.rx_fill = rx_level();
    r.tx_pending = tx_busy;
    replies_due.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one item and return in the time step at which it was taken.
  // push is left high so back-to-back items need no extra cycle.
  task automatic send_item(input logic [2:0] op, input logic [7:0] data);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push <= 1'b1;
    op_i <= op;
    data_i <= data;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    buffer_step(op, data);
    items_sent++;
  endtask

  // Stop offering and wait until every reply has come back
  task automatic drain();
    int n;
    push <= 1'b0;
    n = 0;
    while (replies_due.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all eight registers while the block is idle
  task automatic set_config(input cfg_t c);
    logic [7:0] v;
    drain();
    for (int i = 0; i < 8; i++) begin
      case (3'(i))
        REG_STATUS_CHAR: v = c.status_char;
        REG_START_CHAR:  v = c.start_char;
        REG_HOLD_CHAR:   v = c.hold_char;
        REG_DOOR_CHAR:   v = c.door_char;
        REG_ABORT_CHAR:  v = c.abort_char;
        REG_FLOW_ENABLE: v = {7'd0, c.flow_enable};
        REG_HIGH_MARK:   v = {1'b0, c.high_mark};
        default:         v = {1'b0, c.low_mark};
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_data_i <= v;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg = c;
  endtask

  // ---------------------------------------------------------------------------
  // Reply checker and pop driver
  // ---------------------------------------------------------------------------
  task automatic cmp_field(input string name, input int unsigned exp_v, input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: reply %0d %s mismatch, expected %0h, actual %0h",
               $time, replies_ok, name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (replies_due.size() == 0) begin
          $display("%0t: reply with no item waiting, actual fill %0d event %0d",
                   $time, rx_fill_o, rt_event_o);
          err_cnt++;
        end else begin
          want = replies_due.pop_front();
          cmp_field("read_data", want.read_data, read_data_o);
          cmp_field("read_valid", want.read_valid, read_valid_o);
          cmp_field("tx_byte", want.tx_byte, tx_byte_o);
          cmp_field("tx_valid", want.tx_valid, tx_valid_o);
          cmp_field("rt_event", want.rt_event, rt_event_o);
          cmp_field("write_accepted", want.write_accepted, write_accepted_o);
          cmp_field("rx_dropped", want.rx_dropped, rx_dropped_o);
          cmp_field("rx_fill", want.rx_fill, rx_fill_o);
          cmp_field("tx_pending", want.tx_pending, tx_pending_o);
          replies_ok++;
        end
      end
      pop <= !holding && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Receiver hold-off, counted here so the sender keeps offering meanwhile
  always begin
    @(hold_ev);
    @(posedge clk_i) holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    holding <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset config: empty read, idle transmitter, every event, byte extremes,
  // host writes, ignored ready, spare op codes, flush.
  task automatic test_directed();
    send_item(OP_READ, 8'h00);
    send_item(OP_TXRDY, 8'hFF);
    send_item(OP_RX, cfg.status_char);
    send_item(OP_RX, cfg.start_char);
    send_item(OP_RX, cfg.hold_char);
    send_item(OP_RX, cfg.door_char);
    send_item(OP_RX, cfg.abort_char);
    send_item(OP_RX, 8'h00);
    send_item(OP_RX, 8'hFF);
    send_item(OP_RX, 8'h5A);
    send_item(OP_READ, 8'hFF);
    send_item(OP_READ, 8'h00);
    send_item(OP_WRITE, 8'h00);
    send_item(OP_WRITE, 8'hFF);
    send_item(OP_TXRDY, 8'h00);
    send_item(OP_TXRDY, 8'h00);
    send_item(OP_TXRDY, 8'h00);         // pending already cleared, ignored
    send_item(3'd5, 8'hA5);
    send_item(3'd6, 8'h5A);
    send_item(3'd7, 8'hFF);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_READ, 8'h00);
  endtask

  // Duplicated realtime chars: priority is status, start, hold, door, abort
  task automatic test_duplicate_chars();
    cfg_t c;
    c = cfg;
    c.status_char = 8'h00; c.start_char = 8'h00;
    c.hold_char = 8'hFF; c.door_char = 8'hFF; c.abort_char = 8'hFF;
    set_config(c);
    send_item(OP_RX, 8'h00);
    send_item(OP_RX, 8'hFF);
    c.status_char = 8'h01; c.start_char = 8'h80;
    c.hold_char = 8'h80; c.door_char = 8'h80; c.abort_char = 8'h7F;
    set_config(c);
    send_item(OP_RX, 8'h80);
    send_item(OP_RX, 8'h7F);
    c.start_char = 8'h02; c.hold_char = 8'h03; c.door_char = 8'h55; c.abort_char = 8'h55;
    set_config(c);
    send_item(OP_RX, 8'h55);
  endtask

  // Receive ring fills and drops while the receiver is held off; then the
  // sender pauses for all replies and reads the ring dry.
  task automatic test_rx_overflow();
    cfg_t c;
    c = cfg;
    c.flow_enable = 1'b0;
    set_config(c);
    -> hold_ev;
    repeat (135) send_item(OP_RX, plain_byte());
    drain();
    repeat (130) send_item(OP_READ, 8'($urandom_range(255)));
  endtask

  // Transmit ring fills, refuses writes, then drains; no idling here
  task automatic test_tx_full();
    cfg_t c;
    c = cfg;
    c.flow_enable = 1'b0;
    set_config(c);
    calm <= 1'b1;
    repeat (66) send_item(OP_WRITE, 8'($urandom_range(255)));
    repeat (66) send_item(OP_TXRDY, 8'($urandom_range(255)));
    calm <= 1'b0;
  endtask

  // Fill past the high mark, send XOFF ahead of data, read below the low
  // mark, send XON; optionally flush while XOFF is out.
  task automatic test_flow_round(input logic [6:0] hi, input logic [6:0] lo, input bit flush_it);
    cfg_t c;
    int   n;
    c = cfg;
    c.flow_enable = 1'b1;
    c.high_mark = hi;
    c.low_mark = lo;
    set_config(c);
    n = int'(hi) + 2;
    repeat (n) send_item(OP_RX, plain_byte());
    repeat (3) send_item(OP_WRITE, 8'($urandom_range(255)));
    repeat (2) send_item(OP_TXRDY, 8'($urandom_range(255)));
    if (flush_it) send_item(OP_FLUSH, 8'($urandom_range(255)));
    n = int'(rx_level()) + 1;
    repeat (n) send_item(OP_READ, 8'($urandom_range(255)));
    repeat (6) send_item(OP_TXRDY, 8'($urandom_range(255)));
  endtask

  // XOFF requested, then flow control turned off: ready finds nothing to send
  // and clears the pending flag.
  task automatic test_flow_off_pending();
    cfg_t c;
    c = cfg;
    c.flow_enable = 1'b1;
    c.high_mark = 7'd2;
    c.low_mark = 7'd1;
    set_config(c);
    repeat (3) send_item(OP_RX, plain_byte());
    c.flow_enable = 1'b0;
    set_config(c);
    send_item(OP_TXRDY, 8'h00);
    send_item(OP_FLUSH, 8'hFF);
  endtask

  // Random mix of all ops under random config (fixed extremes in phases 0 and 1), weights shifted per phase
  task automatic test_random_mix(input int phases, input int per_phase);
    cfg_t       c;
    logic [2:0] op;
    logic [7:0] d;
    int         r, w_rx, w_rd, w_wr;
    for (int p = 0; p < phases; p++) begin
      c.status_char = 8'($urandom_range(255));
      c.start_char = 8'($urandom_range(255));
      c.hold_char = 8'($urandom_range(255));
      c.door_char = 8'($urandom_range(255));
      c.abort_char = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) c.door_char = c.start_char;
      c.flow_enable = 1'($urandom_range(1));
      c.high_mark = 7'($urandom_range(30, 3));
      c.low_mark = 7'($urandom_range(c.high_mark, 0));
      if ($urandom_range(4) == 0) begin
        c.high_mark = 7'($urandom_range(127));
        c.low_mark = 7'($urandom_range(127));
      end
      if (p == 0) begin
        c.status_char = 8'h00; c.start_char = 8'h00; c.hold_char = 8'h00;
        c.door_char = 8'h00; c.abort_char = 8'h00;
        c.flow_enable = 1'b1; c.high_mark = 7'd0; c.low_mark = 7'd0;
      end else if (p == 1) begin
        c.status_char = 8'hFF; c.start_char = 8'hFF; c.hold_char = 8'hFF;
        c.door_char = 8'hFF; c.abort_char = 8'hFF;
        c.flow_enable = 1'b1; c.high_mark = 7'd127; c.low_mark = 7'd127;
      end
      set_config(c);
      case (p % 3)
        0:       begin w_rx = 60; w_rd = 15; w_wr = 10; end
        1:       begin w_rx = 35; w_rd = 30; w_wr = 15; end
        default: begin w_rx = 20; w_rd = 20; w_wr = 40; end
      endcase
      if (p == 3) calm <= 1'b1;
      repeat (per_phase) begin
        r = $urandom_range(99);
        d = 8'($urandom_range(255));
        if (r < w_rx) begin
          op = OP_RX;
          if ($urandom_range(3) == 0) begin
            case ($urandom_range(4))
              0:       d = cfg.status_char;
              1:       d = cfg.start_char;
              2:       d = cfg.hold_char;
              3:       d = cfg.door_char;
              default: d = cfg.abort_char;
            endcase
          end
        end else if (r < w_rx + w_rd) op = OP_READ;
        else if (r < w_rx + w_rd + w_wr) op = OP_WRITE;
        else if (r < 95) op = OP_TXRDY;
        else if (r < 98) op = OP_FLUSH;
        else op = 3'($urandom_range(7, 5));
        send_item(op, d);
      end
      if (p == 3) calm <= 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    op_i = OP_RX;
    data_i = 8'h00;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_STATUS_CHAR;
    cfg_data_i = 8'h00;
    // shadow starts at the reset state of the block
    cfg.status_char = 8'd63;
    cfg.start_char = 8'd126;
    cfg.hold_char = 8'd33;
    cfg.door_char = 8'd64;
    cfg.abort_char = 8'd24;
    cfg.flow_enable = 1'b0;
    cfg.high_mark = 7'd96;
    cfg.low_mark = 7'd64;
    rx_hd = '0; rx_tl = '0;
    tx_hd = '0; tx_tl = '0;
    flow = FLOW_XON_SENT;
    tx_busy = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_duplicate_chars();
    test_rx_overflow();
    test_tx_full();
    test_flow_round(7'd6, 7'd3, 1'b0);
    test_flow_round(7'd0, 7'd0, 1'b1);
    test_flow_round(7'd127, 7'd127, 1'b0);
    test_flow_round(7'($urandom_range(60, 20)), 7'($urandom_range(19)), 1'b0);
    test_flow_off_pending();
    test_random_mix(6, 60);

    drain();
    if (replies_due.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, replies_due.size());
      err_cnt += replies_due.size();
    end
    $display("Run: %0d items, %0d replies checked, %0d errors", items_sent, replies_ok, err_cnt);
    $display("Covered: realtime filtering, ring full and empty, XON/XOFF marks, flush, spare ops");
    if (err_cnt == 0) begin
      $display("uart_fifo_realtime_cmd_filter_core_tb passed");
    end else begin
      $display("uart_fifo_realtime_cmd_filter_core_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d replies outstanding", $time, replies_due.size());
    $display("uart_fifo_realtime_cmd_filter_core_tb failed");
    $finish;
  end

endmodule
